// ----- rtl/ppt_pkg.sv -----
// shared types and constants for the planar point transform
`default_nettype none
package ppt_pkg;
	typedef enum logic [2:0] {
		FORM_IDENT  = 3'd0,
		FORM_TRANS  = 3'd1,
		FORM_RIGID  = 3'd2,
		FORM_AFFINE = 3'd3,
		FORM_PROJ   = 3'd4
	} form_t;

	localparam logic [2:0] REG_ROW0  = 3'd0;
	localparam logic [2:0] REG_TXH10 = 3'd1;
	localparam logic [2:0] REG_H11TY = 3'd2;
	localparam logic [2:0] REG_PERSP = 3'd3;
	localparam logic [2:0] REG_SCALE = 3'd4;
	localparam logic [2:0] REG_FORM  = 3'd5;

	localparam logic OP_POINT = 1'b0;
	localparam logic OP_DELTA = 1'b1;

	// per-lane control that travels beside the divider, in the delay line
	typedef struct packed {
		logic neg;
		logic zero;
	} div_ctl_t;
endpackage
`default_nettype wire

// ----- rtl/ppt_div.sv -----
// pipelined restoring divider: (|n| << FRAC_BITS) / |d|, one quotient bit per stage
`default_nettype none
module ppt_div #(
	parameter int FRAC_BITS = 16,
	parameter int NW = 66,
	parameter int QW = 34
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] in_num,
	input  wire logic [NW-1:0] in_den,
	output logic               out_valid,
	output logic [QW-1:0]      out_quo
);
	// the quotient saturates once it passes QW bits; leading bits are folded
	localparam int DW = NW + FRAC_BITS;
	localparam int STG = QW;
	localparam int TOP = DW - QW;

	logic [STG:0]         v_q;
	logic [DW-1:0]        rem_q [STG+1];
	logic [NW-1:0]        den_q [STG+1];
	logic [QW-1:0]        quo_q [STG+1];
	logic                 ovf_q [STG+1];

	// stage 0: high part compared directly; overflow if top part >= den
	logic [DW-1:0] dividend;
	assign dividend = {in_num, {FRAC_BITS{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[STG-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		rem_q[0] <= dividend;
		den_q[0] <= in_den;
		quo_q[0] <= '0;
		// quotient >= 2^QW iff dividend >> QW >= den
		ovf_q[0] <= ({{QW{1'b0}}, dividend[DW-1:QW]} >= {{(DW-NW){1'b0}}, in_den});
	end

	// one quotient bit per stage, from bit QW-1 down to bit 0
	for (genvar k = 0; k < STG; k++) begin : g_stage
		localparam int SH = QW - 1 - k;
		logic [DW-1:0] dsh;
		logic          fit;
		assign dsh = {{(DW-NW){1'b0}}, den_q[k]} << SH;
		assign fit = (rem_q[k] >> SH) >= {{(DW-NW){1'b0}}, den_q[k]};
		always_ff @(posedge clk) begin
			rem_q[k+1] <= fit ? rem_q[k] - dsh : rem_q[k];
			den_q[k+1] <= den_q[k];
			quo_q[k+1] <= quo_q[k] | (QW'(fit) << SH);
			ovf_q[k+1] <= ovf_q[k];
		end
	end

	assign out_valid = v_q[STG];
	assign out_quo = ovf_q[STG] ? '1 : quo_q[STG];
	logic unused;
	assign unused = ^{TOP, rem_q[STG]};
endmodule
`default_nettype wire

// ----- rtl/planar_point_transform.sv -----
// top level of the planar point transform pipeline
//
//  channel | signals                                   | timing
//  cmd     | start, busy, opcode, in_x, in_y, in_dx, in_dy | taken when start && !busy
//  result  | done, out_x, out_y, zero_denominator, saturated | done pulses one cycle
//  config  | cfg_we, cfg_index, cfg_data               | written at a clock edge with cfg_we high
//
// one transaction per cycle; from the cycle in which start is taken, done comes through
// 4 front stages, 35 divider stages (overflow check plus one per quotient bit)
// and 2 back stages, the same for every form. busy stays low.
// reset clears the valid line and loads the identity transform.
// the receiver cannot stall, so nothing in the pipeline ever holds.
`default_nettype none
module planar_point_transform #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        opcode,
	input  wire logic [31:0] in_x,
	input  wire logic [31:0] in_y,
	input  wire logic [31:0] in_dx,
	input  wire logic [31:0] in_dy,
	output logic             done,
	output logic [31:0]      out_x,
	output logic [31:0]      out_y,
	output logic             zero_denominator,
	output logic             saturated,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	import ppt_pkg::*;

	localparam int NW = 66;
	localparam int QW = 34;
	localparam int DLAT = QW + 1;

	// configuration registers
	logic [63:0] row0_q, txh10_q, h11ty_q, persp_q;
	logic [31:0] scale_q;
	logic [2:0]  form_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q  <= 64'(1) << (32 + FRAC_BITS);
			txh10_q <= '0;
			h11ty_q <= 64'(1) << (32 + FRAC_BITS);
			persp_q <= '0;
			scale_q <= 32'(1) << FRAC_BITS;
			form_q  <= FORM_IDENT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW0:  row0_q  <= cfg_data;
				REG_TXH10: txh10_q <= cfg_data;
				REG_H11TY: h11ty_q <= cfg_data;
				REG_PERSP: persp_q <= cfg_data;
				REG_SCALE: scale_q <= cfg_data[31:0];
				REG_FORM:  form_q  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	logic signed [31:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
	assign h00 = row0_q[63:32];
	assign h01 = row0_q[31:0];
	assign h02 = txh10_q[63:32];
	assign h10 = txh10_q[31:0];
	assign h11 = h11ty_q[63:32];
	assign h12 = h11ty_q[31:0];
	assign h20 = persp_q[63:32];
	assign h21 = persp_q[31:0];
	assign h22 = scale_q;

	function automatic logic signed [31:0] clip33(input logic signed [32:0] v,
	                                              output logic s);
		s = (v[32] != v[31]);
		return s ? (v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : v[31:0];
	endfunction

	function automatic logic signed [31:0] clip66(input logic signed [NW-1:0] v,
	                                              output logic s);
		s = (v > 66'sh7fff_ffff) || (v < -66'sh8000_0000);
		return s ? (v[NW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff) : v[31:0];
	endfunction

	assign busy = 1'b0;
	logic acc;
	assign acc = start && !busy;

	// stage 1: capture, form p+dp, pick the two points and the control
	logic        v_s1, op_s1, sat_s1;
	logic [2:0]  form_s1;
	logic signed [31:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic sq1, sq2;
	logic signed [31:0] qx, qy;
	always_comb begin
		qx = clip33(33'(signed'(in_x)) + 33'(signed'(in_dx)), sq1);
		qy = clip33(33'(signed'(in_y)) + 33'(signed'(in_dy)), sq2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= acc;
	end
	always_ff @(posedge clk) begin
		op_s1 <= opcode;
		form_s1 <= form_q;
		sat_s1 <= opcode && form_q == FORM_PROJ && (sq1 || sq2);
		// lane a: p+dp in projective delta, dp for linear delta, p otherwise
		if (opcode == OP_DELTA && form_q == FORM_PROJ) begin
			ax_s1 <= qx; ay_s1 <= qy;
		end else if (opcode == OP_DELTA) begin
			ax_s1 <= in_dx; ay_s1 <= in_dy;
		end else begin
			ax_s1 <= in_x; ay_s1 <= in_y;
		end
		bx_s1 <= in_x; by_s1 <= in_y;
	end

	// stage 2: products for both lanes
	logic        v_s2, op_s2, sat_s2;
	logic [2:0]  form_s2;
	logic signed [63:0] p_s2 [12];
	logic signed [31:0] ax_s2, ay_s2;
	logic        lin_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		op_s2 <= op_s1; form_s2 <= form_s1; sat_s2 <= sat_s1;
		ax_s2 <= ax_s1; ay_s2 <= ay_s1;
		lin_s2 <= (op_s1 == OP_DELTA);
		p_s2[0]  <= ax_s1 * h00; p_s2[1]  <= ay_s1 * h01;
		p_s2[2]  <= ax_s1 * h10; p_s2[3]  <= ay_s1 * h11;
		p_s2[4]  <= ax_s1 * h20; p_s2[5]  <= ay_s1 * h21;
		p_s2[6]  <= bx_s1 * h00; p_s2[7]  <= by_s1 * h01;
		p_s2[8]  <= bx_s1 * h10; p_s2[9]  <= by_s1 * h11;
		p_s2[10] <= bx_s1 * h20; p_s2[11] <= by_s1 * h21;
	end

	// stage 3: row sums; the linear delta drops the constant column
	logic        v_s3, op_s3, sat_s3;
	logic [2:0]  form_s3;
	logic signed [NW-1:0] n_s3 [4];
	logic signed [NW-1:0] z_s3 [2];
	logic signed [31:0] ax_s3, ay_s3;
	logic signed [NW-1:0] c02, c12, c22;
	assign c02 = NW'(h02) <<< FRAC_BITS;
	assign c12 = NW'(h12) <<< FRAC_BITS;
	assign c22 = NW'(h22) <<< FRAC_BITS;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		op_s3 <= op_s2; form_s3 <= form_s2; sat_s3 <= sat_s2;
		ax_s3 <= ax_s2; ay_s3 <= ay_s2;
		n_s3[0] <= NW'(p_s2[0]) + NW'(p_s2[1]) + ((lin_s2 && form_s2 != FORM_PROJ) ? '0 : c02);
		n_s3[1] <= NW'(p_s2[2]) + NW'(p_s2[3]) + ((lin_s2 && form_s2 != FORM_PROJ) ? '0 : c12);
		z_s3[0] <= NW'(p_s2[4]) + NW'(p_s2[5]) + c22;
		n_s3[2] <= NW'(p_s2[6]) + NW'(p_s2[7]) + c02;
		n_s3[3] <= NW'(p_s2[8]) + NW'(p_s2[9]) + c12;
		z_s3[1] <= NW'(p_s2[10]) + NW'(p_s2[11]) + c22;
	end

	// stage 4: magnitudes and signs for the divider, direct results otherwise
	logic        v_s4, op_s4, sat_s4;
	logic [2:0]  form_s4;
	logic [NW-1:0] mn_s4 [4];
	logic [NW-1:0] md_s4 [4];
	div_ctl_t    dc_s4 [4];
	logic signed [31:0] rx_s4, ry_s4;
	logic        rsat_s4;
	logic signed [31:0] t0, t1, t2, t3;
	logic s0, s1, s2, s3;
	logic signed [31:0] rx_n, ry_n;
	logic        rsat_n;
	always_comb begin
		t0 = clip33(33'(ax_s3) + 33'(h02), s0);
		t1 = clip33(33'(ay_s3) + 33'(h12), s1);
		t2 = clip66(n_s3[0] >>> FRAC_BITS, s2);
		t3 = clip66(n_s3[1] >>> FRAC_BITS, s3);
		rsat_n = 1'b0;
		rx_n = '0;
		ry_n = '0;
		unique case (form_s3)
			FORM_IDENT: begin
				rx_n = ax_s3; ry_n = ay_s3;
			end
			FORM_TRANS: begin
				if (op_s3 == OP_DELTA) begin
					rx_n = ax_s3; ry_n = ay_s3;
				end else begin
					rx_n = t0; ry_n = t1; rsat_n = s0 || s1;
				end
			end
			FORM_RIGID, FORM_AFFINE: begin
				rx_n = t2; ry_n = t3; rsat_n = s2 || s3;
			end
			default: ;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		op_s4 <= op_s3; form_s4 <= form_s3; sat_s4 <= sat_s3;
		rsat_s4 <= rsat_n;
		rx_s4 <= rx_n; ry_s4 <= ry_n;
		for (int i = 0; i < 4; i++) begin
			mn_s4[i] <= n_s3[i][NW-1] ? NW'(-n_s3[i]) : n_s3[i];
			md_s4[i] <= z_s3[i/2][NW-1] ? NW'(-z_s3[i/2]) : z_s3[i/2];
			dc_s4[i].neg <= n_s3[i][NW-1] ^ z_s3[i/2][NW-1];
			dc_s4[i].zero <= (z_s3[i/2] == '0);
		end
	end

	// divider lanes; a zero divisor is replaced by one and its quotient is not used
	logic [QW-1:0] q_d [4];
	logic          dv [4];
	for (genvar i = 0; i < 4; i++) begin : g_div
		ppt_div #(.FRAC_BITS(FRAC_BITS), .NW(NW), .QW(QW)) u_div (
			.clk(clk), .arst_n(arst_n), .in_valid(v_s4),
			.in_num(mn_s4[i]), .in_den(md_s4[i] == '0 ? NW'(1) : md_s4[i]),
			.out_valid(dv[i]), .out_quo(q_d[i])
		);
	end

	// delay line for the side data across the divider
	logic        dl_op [DLAT], dl_sat [DLAT], dl_rsat [DLAT];
	logic [2:0]  dl_form [DLAT];
	logic signed [31:0] dl_rx [DLAT], dl_ry [DLAT];
	div_ctl_t    dl_dc [DLAT][4];
	always_ff @(posedge clk) begin
		dl_op[0] <= op_s4; dl_sat[0] <= sat_s4; dl_rsat[0] <= rsat_s4;
		dl_form[0] <= form_s4; dl_rx[0] <= rx_s4; dl_ry[0] <= ry_s4;
		dl_dc[0] <= dc_s4;
		for (int k = 1; k < DLAT; k++) begin
			dl_op[k] <= dl_op[k-1]; dl_sat[k] <= dl_sat[k-1];
			dl_rsat[k] <= dl_rsat[k-1]; dl_form[k] <= dl_form[k-1];
			dl_rx[k] <= dl_rx[k-1]; dl_ry[k] <= dl_ry[k-1];
			dl_dc[k] <= dl_dc[k-1];
		end
	end

	// stage 5: sign and clip the quotients
	localparam int LL = DLAT - 1;
	logic        v_s5, op_s5, sat_s5, zd_s5;
	logic [2:0]  form_s5;
	logic signed [31:0] rx_s5, ry_s5, m_s5 [4];
	logic signed [31:0] mq [4];
	logic ms [4];
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (dl_dc[LL][i].zero) begin
				mq[i] = '0; ms[i] = 1'b0;
			end else if (dl_dc[LL][i].neg) begin
				ms[i] = q_d[i] > QW'(33'h0_8000_0000);
				mq[i] = ms[i] ? 32'sh8000_0000 : 32'(-q_d[i]);
			end else begin
				ms[i] = q_d[i] > QW'(33'h0_7fff_ffff);
				mq[i] = ms[i] ? 32'sh7fff_ffff : q_d[i][31:0];
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= dv[0];
	end
	always_ff @(posedge clk) begin
		op_s5 <= dl_op[LL]; form_s5 <= dl_form[LL];
		rx_s5 <= dl_rx[LL]; ry_s5 <= dl_ry[LL];
		m_s5 <= mq;
		if (dl_form[LL] == FORM_PROJ) begin
			if (dl_op[LL] == OP_DELTA) begin
				sat_s5 <= dl_sat[LL] || ms[0] || ms[1] || ms[2] || ms[3];
				zd_s5 <= dl_dc[LL][0].zero || dl_dc[LL][2].zero;
			end else begin
				sat_s5 <= ms[0] || ms[1];
				zd_s5 <= dl_dc[LL][0].zero;
			end
		end else begin
			sat_s5 <= dl_rsat[LL]; zd_s5 <= 1'b0;
		end
	end

	// stage 6: difference for projective delta and final select
	logic sdx, sdy;
	logic signed [31:0] ddx, ddy;
	always_comb begin
		ddx = clip33(33'(m_s5[0]) - 33'(m_s5[2]), sdx);
		ddy = clip33(33'(m_s5[1]) - 33'(m_s5[3]), sdy);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s5;
	end
	always_ff @(posedge clk) begin
		zero_denominator <= zd_s5;
		if (form_s5 == FORM_PROJ && op_s5 == OP_DELTA) begin
			out_x <= ddx; out_y <= ddy; saturated <= sat_s5 || sdx || sdy;
		end else if (form_s5 == FORM_PROJ) begin
			out_x <= m_s5[0]; out_y <= m_s5[1]; saturated <= sat_s5;
		end else begin
			out_x <= rx_s5; out_y <= ry_s5; saturated <= sat_s5;
		end
	end

	logic unused;
	assign unused = ^{dv[1], dv[2], dv[3]};
endmodule
`default_nettype wire

// ----- rtl/ppt_checker.sv -----
// port-level checks for the planar point transform, bound to the top level
`default_nettype none
module ppt_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic zero_denominator,
	input wire logic saturated,
	input wire logic [31:0] out_x,
	input wire logic [31:0] out_y
);
	// the block never refuses a transaction
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	// a result carries known values on every port
	a_known_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown({out_x, out_y, zero_denominator, saturated}))
		else $error("unknown result value");
	// no result without a matching earlier command on start
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 41))
		else $error("result without command");
endmodule

bind planar_point_transform ppt_checker u_ppt_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.zero_denominator(zero_denominator), .saturated(saturated),
	.out_x(out_x), .out_y(out_y)
);
`default_nettype wire
